// File: rtl/cbda_pkg.sv
// Shared types, codes and constants of the block chain directory allocator.
package cbda_pkg;

   // Directory geometry.
   localparam int SLOTS       = 15;
   localparam int SLOT_W      = 4;
   localparam int WALK_MAX    = (SLOTS < 15) ? SLOTS : 15;
   localparam int BLOCK_BYTES = 8192;

   // Block type bytes.
   localparam logic [7:0] TYPE_FREE     = 8'hA0;
   localparam logic [7:0] TYPE_INITIAL  = 8'h51;
   localparam logic [7:0] TYPE_MIDDLE   = 8'h52;
   localparam logic [7:0] TYPE_END      = 8'h53;
   localparam logic [7:0] TYPE_DEL_INIT = 8'hA1;
   localparam logic [7:0] TYPE_DEL_MID  = 8'hA2;
   localparam logic [7:0] TYPE_DEL_END  = 8'hA3;
   localparam logic [7:0] LINK_NONE     = 8'hFF;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_TOGGLE = 2'd1,
      KIND_FORMAT = 2'd2,
      KIND_ALLOC  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CLS_FREE     = 3'd0,
      CLS_INITIAL  = 3'd1,
      CLS_MIDDLE   = 3'd2,
      CLS_END      = 3'd3,
      CLS_DEL_INIT = 3'd4,
      CLS_DEL_MID  = 3'd5,
      CLS_DEL_END  = 3'd6,
      CLS_CORRUPT  = 3'd7
   } class_type;

   typedef struct packed {
      logic [7:0]  code;
      logic [7:0]  link;
      logic [23:0] size;
   } dir_entry_type;

   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   addr;
      dir_entry_type       entry;
   } wr_port_type;

   typedef struct packed {
      class_type  cls;
      logic [7:0] toggled;
      logic       is_free;
      logic       chain_end;
   } entry_info_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [7:0]        code;
      logic [7:0]        link;
      logic [23:0]       size;
      class_type         cls;
      logic              status;
      logic              last;
   } result_type;

   // Size of a fresh allocation: count blocks, kept to 24 bits.
   function automatic logic [23:0] alloc_size(input logic [SLOT_W-1:0] cnt);
      logic [47:0] prod;
      prod = 48'(cnt) * 48'(BLOCK_BYTES);
      return prod[23:0];
   endfunction

endpackage

// File: rtl/cbda_dir_store.sv
// Directory storage: one entry per slot, one read port and one write port.
module cbda_dir_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cbda_pkg::SLOT_W-1:0]   rd_addr,
   output cbda_pkg::dir_entry_type       rd_entry,
   input  cbda_pkg::wr_port_type         wr
);

   cbda_pkg::dir_entry_type entries_ff [cbda_pkg::SLOTS];
   cbda_pkg::dir_entry_type blank;

   assign blank = '{code: cbda_pkg::TYPE_FREE, link: cbda_pkg::LINK_NONE, size: 24'd0};

   // Read port; an address past the table reads as a blank entry.
   always_comb begin
      if (9'(rd_addr) < 9'(cbda_pkg::SLOTS)) begin
         rd_entry = entries_ff[rd_addr];
      end else begin
         rd_entry = blank;
      end
   end

   // Reset leaves every block free and unlinked.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbda_pkg::SLOTS; i++) begin
            entries_ff[i] <= blank;
         end
      end else if (wr.en && (9'(wr.addr) < 9'(cbda_pkg::SLOTS))) begin
         entries_ff[wr.addr] <= wr.entry;
      end
   end

endmodule

// File: rtl/cbda_entry_unit.sv
// Shared entry unit: classifies one entry and derives its toggled type and chain tests.
module cbda_entry_unit (
   input  cbda_pkg::dir_entry_type  entry,
   output cbda_pkg::entry_info_type info
);

   cbda_pkg::class_type cls;
   logic [7:0]          toggled;

   // Type byte to block class.
   always_comb begin
      case (entry.code)
         cbda_pkg::TYPE_FREE:     cls = cbda_pkg::CLS_FREE;
         cbda_pkg::TYPE_INITIAL:  cls = cbda_pkg::CLS_INITIAL;
         cbda_pkg::TYPE_MIDDLE:   cls = cbda_pkg::CLS_MIDDLE;
         cbda_pkg::TYPE_END:      cls = cbda_pkg::CLS_END;
         cbda_pkg::TYPE_DEL_INIT: cls = cbda_pkg::CLS_DEL_INIT;
         cbda_pkg::TYPE_DEL_MID:  cls = cbda_pkg::CLS_DEL_MID;
         cbda_pkg::TYPE_DEL_END:  cls = cbda_pkg::CLS_DEL_END;
         default:                 cls = cbda_pkg::CLS_CORRUPT;
      endcase
   end

   // Used and deleted types swap pairwise; anything else stays.
   always_comb begin
      case (entry.code)
         cbda_pkg::TYPE_INITIAL:  toggled = cbda_pkg::TYPE_DEL_INIT;
         cbda_pkg::TYPE_MIDDLE:   toggled = cbda_pkg::TYPE_DEL_MID;
         cbda_pkg::TYPE_END:      toggled = cbda_pkg::TYPE_DEL_END;
         cbda_pkg::TYPE_DEL_INIT: toggled = cbda_pkg::TYPE_INITIAL;
         cbda_pkg::TYPE_DEL_MID:  toggled = cbda_pkg::TYPE_MIDDLE;
         cbda_pkg::TYPE_DEL_END:  toggled = cbda_pkg::TYPE_END;
         default:                 toggled = entry.code;
      endcase
   end

   // A chain ends at a corrupted entry or at a link that leaves the table.
   always_comb begin
      info.cls       = cls;
      info.toggled   = toggled;
      info.is_free   = (entry.code == cbda_pkg::TYPE_FREE);
      info.chain_end = (cls == cbda_pkg::CLS_CORRUPT) ||
                       (9'(entry.link) >= 9'(cbda_pkg::SLOTS));
   end

endmodule

// File: rtl/cbda_sequencer.sv
// Sequencer: walks chains, scans for free runs, applies edits and lists touched entries.
module cbda_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   // Incoming word.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cbda_pkg::kind_type            req_kind,
   input  logic [cbda_pkg::SLOT_W-1:0]   req_slot,
   input  logic [7:0]                    req_code,
   input  logic [7:0]                    req_link,
   input  logic [23:0]                   req_size,
   input  logic [cbda_pkg::SLOT_W-1:0]   req_count,
   // Directory access and shared entry unit.
   output logic [cbda_pkg::SLOT_W-1:0]   rd_addr,
   input  cbda_pkg::dir_entry_type       rd_entry,
   input  cbda_pkg::entry_info_type      info,
   output cbda_pkg::wr_port_type         wr,
   // Result words toward the output register.
   output logic                          emit_valid,
   input  logic                          emit_ready,
   output cbda_pkg::result_type          emit_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_APPLY,
      ST_EMIT,
      ST_SCAN,
      ST_ALLOC,
      ST_SINGLE
   } state_type;

   localparam logic [cbda_pkg::SLOT_W-1:0] LAST_SLOT = cbda_pkg::SLOT_W'(cbda_pkg::SLOTS - 1);
   localparam logic [cbda_pkg::SLOT_W-1:0] LAST_WALK =
      cbda_pkg::SLOT_W'(cbda_pkg::WALK_MAX - 1);

   state_type                   state_ff,    state_in;
   cbda_pkg::kind_type          kind_ff,     kind_in;
   logic [cbda_pkg::SLOT_W-1:0] idx_ff,      idx_in;
   logic [cbda_pkg::SLOT_W-1:0] last_idx_ff, last_idx_in;
   logic [cbda_pkg::SLOT_W-1:0] cur_ff,      cur_in;
   logic [cbda_pkg::SLOT_W-1:0] run_ff,      run_in;
   logic [cbda_pkg::SLOT_W-1:0] cnt_ff,      cnt_in;
   logic [cbda_pkg::SLOT_W-1:0] start_ff,    start_in;
   logic [cbda_pkg::SLOT_W-1:0] list_ff  [cbda_pkg::WALK_MAX];
   logic [cbda_pkg::SLOT_W-1:0] list_in  [cbda_pkg::WALK_MAX];
   logic                        touched_ff [cbda_pkg::SLOTS];
   logic                        touched_in [cbda_pkg::SLOTS];
   cbda_pkg::result_type        single_ff,   single_in;
   cbda_pkg::result_type        fail_word;
   logic [cbda_pkg::SLOT_W-1:0] alloc_slot;
   logic                        alloc_last;

   assign fail_word = '{slot: '0, code: 8'd0, link: 8'd0, size: 24'd0,
                        cls: cbda_pkg::CLS_FREE, status: cbda_pkg::STATUS_NO_SPACE,
                        last: 1'b1};
   assign alloc_slot = start_ff + idx_ff;
   assign alloc_last = (idx_ff == cnt_ff - cbda_pkg::SLOT_W'(1));

   // Next-state logic for the whole item.
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      cur_in      = cur_ff;
      run_in      = run_ff;
      cnt_in      = cnt_ff;
      start_in    = start_ff;
      list_in     = list_ff;
      touched_in  = touched_ff;
      single_in   = single_ff;
      req_ready   = (state_ff == ST_IDLE);
      rd_addr     = cur_ff;
      wr          = '0;
      emit_valid  = 1'b0;
      emit_data   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               idx_in  = '0;
               run_in  = '0;
               cnt_in  = req_count;
               for (int i = 0; i < cbda_pkg::SLOTS; i++) begin
                  touched_in[i] = 1'b0;
               end
               if (req_kind == cbda_pkg::KIND_ALLOC) begin
                  if ((req_count == '0) || (9'(req_count) > 9'(cbda_pkg::SLOTS))) begin
                     single_in = fail_word;
                     state_in  = ST_SINGLE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (9'(req_slot) >= 9'(cbda_pkg::SLOTS)) begin
                  // Start slot outside the table: nothing changes.
                  single_in = '{slot: req_slot, code: 8'd0, link: cbda_pkg::LINK_NONE,
                                size: 24'd0, cls: cbda_pkg::CLS_CORRUPT,
                                status: cbda_pkg::STATUS_OK, last: 1'b1};
                  state_in  = ST_SINGLE;
               end else if (req_kind == cbda_pkg::KIND_LOAD) begin
                  wr.en       = 1'b1;
                  wr.addr     = req_slot;
                  wr.entry    = '{code: req_code, link: req_link, size: req_size};
                  list_in[0]  = req_slot;
                  last_idx_in = '0;
                  state_in    = ST_EMIT;
               end else begin
                  cur_in   = req_slot;
                  state_in = ST_WALK;
               end
            end
         end

         // Record the chain entry by entry before anything is changed.
         ST_WALK: begin
            rd_addr         = cur_ff;
            list_in[idx_ff] = cur_ff;
            if (info.chain_end || (idx_ff == LAST_WALK)) begin
               last_idx_in = idx_ff;
               idx_in      = '0;
               state_in    = ST_APPLY;
            end else begin
               cur_in = rd_entry.link[cbda_pkg::SLOT_W-1:0];
               idx_in = idx_ff + cbda_pkg::SLOT_W'(1);
            end
         end

         // Edit each listed entry; a looping chain toggles an entry only once.
         ST_APPLY: begin
            rd_addr = list_ff[idx_ff];
            if (kind_ff == cbda_pkg::KIND_FORMAT) begin
               wr.en    = 1'b1;
               wr.addr  = rd_addr;
               wr.entry = '{code: cbda_pkg::TYPE_FREE, link: cbda_pkg::LINK_NONE,
                            size: 24'd0};
            end else if (!touched_ff[rd_addr]) begin
               wr.en               = 1'b1;
               wr.addr             = rd_addr;
               wr.entry            = '{code: info.toggled, link: rd_entry.link,
                                       size: rd_entry.size};
               touched_in[rd_addr] = 1'b1;
            end
            if (idx_ff == last_idx_ff) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + cbda_pkg::SLOT_W'(1);
            end
         end

         // List every touched entry as it now stands.
         ST_EMIT: begin
            rd_addr    = list_ff[idx_ff];
            emit_valid = 1'b1;
            emit_data  = '{slot: rd_addr, code: rd_entry.code, link: rd_entry.link,
                           size: rd_entry.size, cls: info.cls,
                           status: cbda_pkg::STATUS_OK, last: (idx_ff == last_idx_ff)};
            if (emit_ready) begin
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + cbda_pkg::SLOT_W'(1);
               end
            end
         end

         // Count consecutive free blocks; the first run to reach the count is lowest.
         ST_SCAN: begin
            rd_addr = idx_ff;
            if (info.is_free && ((run_ff + cbda_pkg::SLOT_W'(1)) == cnt_ff)) begin
               start_in = idx_ff - cnt_ff + cbda_pkg::SLOT_W'(1);
               idx_in   = '0;
               state_in = ST_ALLOC;
            end else begin
               run_in = info.is_free ? (run_ff + cbda_pkg::SLOT_W'(1)) : '0;
               if (idx_ff == LAST_SLOT) begin
                  single_in = fail_word;
                  state_in  = ST_SINGLE;
               end else begin
                  idx_in = idx_ff + cbda_pkg::SLOT_W'(1);
               end
            end
         end

         // Link the run as initial, middle and end blocks.
         ST_ALLOC: begin
            rd_addr = alloc_slot;
            wr.en   = 1'b1;
            wr.addr = alloc_slot;
            if (idx_ff == '0) begin
               wr.entry.code = cbda_pkg::TYPE_INITIAL;
               wr.entry.size = cbda_pkg::alloc_size(cnt_ff);
            end else begin
               wr.entry.code = alloc_last ? cbda_pkg::TYPE_END : cbda_pkg::TYPE_MIDDLE;
               wr.entry.size = rd_entry.size;
            end
            wr.entry.link   = alloc_last ? cbda_pkg::LINK_NONE : (8'(alloc_slot) + 8'd1);
            list_in[idx_ff] = alloc_slot;
            if (alloc_last) begin
               last_idx_in = idx_ff;
               idx_in      = '0;
               state_in    = ST_EMIT;
            end else begin
               idx_in = idx_ff + cbda_pkg::SLOT_W'(1);
            end
         end

         // One fixed result word: failed allocation or start slot out of range.
         ST_SINGLE: begin
            emit_valid = 1'b1;
            emit_data  = single_ff;
            if (emit_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff     <= kind_in;
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      cur_ff      <= cur_in;
      run_ff      <= run_in;
      cnt_ff      <= cnt_in;
      start_ff    <= start_in;
      list_ff     <= list_in;
      touched_ff  <= touched_in;
      single_ff   <= single_in;
   end

endmodule

// File: rtl/block_chain_directory_allocator_unit.sv
// Top level of the block chain directory allocator.
// Keeps a fifteen-entry card directory and serves four commands: load an entry, toggle the
// deleted state along a chain, format a chain, and allocate the lowest run of free blocks.
// One entry is read and at most one written per cycle through a single shared entry unit,
// so no new word is taken until the last result word of an item has entered the output
// register. A load writes its entry and lists it; a toggle or format walks the chain, edits
// the listed entries and then lists them; an allocation scans for the lowest free run, links
// it and lists it, or yields one no-space word. Result words wait in an output register, so
// the listing stalls only when that register is full and not drained.
module block_chain_directory_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot[3:0], type_code[11:4], link[19:12], size_bytes[43:20], count[47:44]
   input  logic [47:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_slot[3:0], out_type[11:4], out_link[19:12], out_size[43:20],
   // block_class[46:44], zero[47]
   output logic [47:0] rsp_tdata,
   // status[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic [cbda_pkg::SLOT_W-1:0] rd_addr;
   cbda_pkg::dir_entry_type     rd_entry;
   cbda_pkg::entry_info_type    info;
   cbda_pkg::wr_port_type       wr;
   logic                        emit_valid;
   logic                        emit_ready;
   cbda_pkg::result_type        emit_data;
   logic                        rsp_valid_ff, rsp_valid_in;
   cbda_pkg::result_type        rsp_word_ff,  rsp_word_in;

   cbda_dir_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   cbda_entry_unit u_entry (
      .entry (rd_entry),
      .info  (info)
   );

   cbda_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (cbda_pkg::kind_type'(req_tuser)),
      .req_slot   (req_tdata[3:0]),
      .req_code   (req_tdata[11:4]),
      .req_link   (req_tdata[19:12]),
      .req_size   (req_tdata[43:20]),
      .req_count  (req_tdata[47:44]),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry),
      .info       (info),
      .wr         (wr),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .emit_data  (emit_data)
   );

   // Output register: loads when empty or when its word is taken this cycle.
   assign emit_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (emit_valid && emit_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_word_ff.cls, rsp_word_ff.size, rsp_word_ff.link,
                        rsp_word_ff.code, rsp_word_ff.slot};
   assign rsp_tuser  = rsp_word_ff.status;
   assign rsp_tlast  = rsp_word_ff.last;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the block chain directory allocator unit.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [cbda_pkg::SLOT_W-1:0] slot;
      logic [7:0]                  code;
      logic [7:0]                  link;
      logic [23:0]                 nbytes;
      cbda_pkg::class_type         cls;
      logic                        status;
      logic                        last;
   } dir_word_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // slot[3:0], type_code[11:4], link[19:12], size_bytes[43:20], count[47:44]
   logic [47:0] req_tdata = '0;
   // kind[1:0]
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // out_slot[3:0], out_type[11:4], out_link[19:12], out_size[43:20],
   // block_class[46:44], zero[47]
   logic [47:0] rsp_tdata;
   // status[0]
   logic [0:0] rsp_tuser;
   logic rsp_tlast;

   // Shadow copy of the directory, updated as each command word is accepted.
   logic [7:0]  dir_code [cbda_pkg::SLOTS];
   logic [7:0]  dir_link [cbda_pkg::SLOTS];
   logic [23:0] dir_size [cbda_pkg::SLOTS];

   dir_word_type expected_words [$];
   int mismatch_count = 0;
   int words_checked = 0;
   int commands_by_kind [4] = '{0, 0, 0, 0};
   int no_space_count = 0;
   int cycle_count = 0;
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;

   block_chain_directory_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Reset held from the start, released on a falling edge.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, expected_words.size());
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic cbda_pkg::class_type class_of(input logic [7:0] code);
      case (code)
         cbda_pkg::TYPE_FREE:     return cbda_pkg::CLS_FREE;
         cbda_pkg::TYPE_INITIAL:  return cbda_pkg::CLS_INITIAL;
         cbda_pkg::TYPE_MIDDLE:   return cbda_pkg::CLS_MIDDLE;
         cbda_pkg::TYPE_END:      return cbda_pkg::CLS_END;
         cbda_pkg::TYPE_DEL_INIT: return cbda_pkg::CLS_DEL_INIT;
         cbda_pkg::TYPE_DEL_MID:  return cbda_pkg::CLS_DEL_MID;
         cbda_pkg::TYPE_DEL_END:  return cbda_pkg::CLS_DEL_END;
         default:                 return cbda_pkg::CLS_CORRUPT;
      endcase
   endfunction

   // Used and deleted codes swap pairwise; anything else stays put.
   function automatic logic [7:0] flip_deleted(input logic [7:0] code);
      case (code)
         cbda_pkg::TYPE_INITIAL:  return cbda_pkg::TYPE_DEL_INIT;
         cbda_pkg::TYPE_MIDDLE:   return cbda_pkg::TYPE_DEL_MID;
         cbda_pkg::TYPE_END:      return cbda_pkg::TYPE_DEL_END;
         cbda_pkg::TYPE_DEL_INIT: return cbda_pkg::TYPE_INITIAL;
         cbda_pkg::TYPE_DEL_MID:  return cbda_pkg::TYPE_MIDDLE;
         cbda_pkg::TYPE_DEL_END:  return cbda_pkg::TYPE_END;
         default:                 return code;
      endcase
   endfunction

   function automatic dir_word_type entry_word(input int idx, input logic last);
      dir_word_type w;
      w.slot   = idx[cbda_pkg::SLOT_W-1:0];
      w.code   = dir_code[idx];
      w.link   = dir_link[idx];
      w.nbytes = dir_size[idx];
      w.cls    = class_of(dir_code[idx]);
      w.status = cbda_pkg::STATUS_OK;
      w.last   = last;
      return w;
   endfunction

   // Applies one command to the shadow directory and queues the words it yields.
   task automatic predict_directory_update(input cbda_pkg::kind_type k,
                                           input logic [3:0] slot,
                                           input logic [7:0] code, input logic [7:0] link,
                                           input logic [23:0] nbytes, input logic [3:0] cnt);
      int visited [$];
      logic [7:0] prior [$];
      int cur, base, j;
      bit fits;
      dir_word_type w;
      commands_by_kind[k]++;
      if (k == cbda_pkg::KIND_ALLOC) begin
         base = -1;
         if (cnt != 0) begin
            for (int s = 0; s + int'(cnt) <= cbda_pkg::SLOTS && base < 0; s++) begin
               fits = 1'b1;
               for (j = 0; j < int'(cnt); j++)
                  if (dir_code[s + j] != cbda_pkg::TYPE_FREE) fits = 1'b0;
               if (fits) base = s;
            end
         end
         if (base < 0) begin
            w = '0;
            w.cls = cbda_pkg::CLS_FREE;
            w.status = cbda_pkg::STATUS_NO_SPACE;
            w.last = 1'b1;
            expected_words.push_back(w);
            no_space_count++;
            return;
         end
         for (j = 0; j < int'(cnt); j++) begin
            if (j + 1 < int'(cnt)) begin
               dir_code[base + j] = cbda_pkg::TYPE_MIDDLE;
               dir_link[base + j] = 8'(base + j + 1);
            end else begin
               dir_code[base + j] = cbda_pkg::TYPE_END;
               dir_link[base + j] = cbda_pkg::LINK_NONE;
            end
         end
         dir_code[base] = cbda_pkg::TYPE_INITIAL;
         dir_size[base] = 24'(int'(cnt) * cbda_pkg::BLOCK_BYTES);
         for (j = 0; j < int'(cnt); j++)
            expected_words.push_back(entry_word(base + j, j + 1 == int'(cnt)));
         return;
      end
      // A start slot past the table leaves the directory untouched.
      if (int'(slot) >= cbda_pkg::SLOTS) begin
         w.slot = slot;
         w.code = 8'h00;
         w.link = cbda_pkg::LINK_NONE;
         w.nbytes = '0;
         w.cls = cbda_pkg::CLS_CORRUPT;
         w.status = cbda_pkg::STATUS_OK;
         w.last = 1'b1;
         expected_words.push_back(w);
         return;
      end
      if (k == cbda_pkg::KIND_LOAD) begin
         dir_code[slot] = code;
         dir_link[slot] = link;
         dir_size[slot] = nbytes;
         expected_words.push_back(entry_word(int'(slot), 1'b1));
         return;
      end
      // Walk the whole chain first, then edit every visited entry.
      cur = int'(slot);
      while (visited.size() < cbda_pkg::WALK_MAX) begin
         visited.push_back(cur);
         if (class_of(dir_code[cur]) == cbda_pkg::CLS_CORRUPT) break;
         if (dir_link[cur] == cbda_pkg::LINK_NONE || int'(dir_link[cur]) >= cbda_pkg::SLOTS)
            break;
         cur = int'(dir_link[cur]);
      end
      foreach (visited[i]) prior.push_back(dir_code[visited[i]]);
      foreach (visited[i]) begin
         if (k == cbda_pkg::KIND_TOGGLE) begin
            dir_code[visited[i]] = flip_deleted(prior[i]);
         end else begin
            dir_code[visited[i]] = cbda_pkg::TYPE_FREE;
            dir_link[visited[i]] = cbda_pkg::LINK_NONE;
            dir_size[visited[i]] = '0;
         end
      end
      foreach (visited[i]) begin
         expected_words.push_back(entry_word(visited[i], i + 1 == visited.size()));
      end
   endtask

   // Sends one command word after a random gap and predicts its results on acceptance.
   task automatic send_command(input cbda_pkg::kind_type k, input logic [3:0] slot,
                               input logic [7:0] code, input logic [7:0] link,
                               input logic [23:0] nbytes, input logic [3:0] cnt);
      int gap;
      gap = sender_gaps ? int'($urandom_range(0, 6)) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {cnt, nbytes, link, code, slot};
      do @(posedge clock); while (!req_tready);
      predict_directory_update(k, slot, code, link, nbytes, cnt);
   endtask

   // Result side: random stall before each word, then hold ready until one is taken.
   initial begin
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = receiver_stalls ? int'($urandom_range(0, 6)) : 0;
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin
      dir_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word for slot %0d with nothing expected",
                                      rsp_tdata[3:0]));
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata[3:0] !== want.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", rsp_tdata[3:0], want.slot));
            if (rsp_tdata[11:4] !== want.code)
               report_mismatch($sformatf("slot %0d type %02h, expected %02h",
                                         want.slot, rsp_tdata[11:4], want.code));
            if (rsp_tdata[19:12] !== want.link)
               report_mismatch($sformatf("slot %0d link %02h, expected %02h",
                                         want.slot, rsp_tdata[19:12], want.link));
            if (rsp_tdata[43:20] !== want.nbytes)
               report_mismatch($sformatf("slot %0d size %06h, expected %06h",
                                         want.slot, rsp_tdata[43:20], want.nbytes));
            if (rsp_tdata[46:44] !== 3'(want.cls))
               report_mismatch($sformatf("slot %0d class %0d, expected %0d",
                                         want.slot, rsp_tdata[46:44], want.cls));
            if (rsp_tdata[47] !== 1'b0)
               report_mismatch($sformatf("slot %0d padding bit set", want.slot));
            if (rsp_tuser[0] !== want.status)
               report_mismatch($sformatf("slot %0d status %b, expected %b",
                                         want.slot, rsp_tuser[0], want.status));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("slot %0d last %b, expected %b",
                                         want.slot, rsp_tlast, want.last));
         end
      end
   end

   // Picks the head of a live or deleted chain when there is one.
   function automatic logic [3:0] chain_head_slot();
      int off, idx;
      off = int'($urandom_range(0, cbda_pkg::SLOTS - 1));
      for (int i = 0; i < cbda_pkg::SLOTS; i++) begin
         idx = (off + i) % cbda_pkg::SLOTS;
         if (dir_code[idx] == cbda_pkg::TYPE_INITIAL || dir_code[idx] == cbda_pkg::TYPE_DEL_INIT)
            return 4'(idx);
      end
      return 4'($urandom_range(0, 15));
   endfunction

   task automatic send_random_command();
      int pick;
      logic [3:0] slot, cnt;
      logic [7:0] code, link;
      logic [23:0] nbytes;
      pick   = int'($urandom_range(0, 99));
      slot   = 4'($urandom_range(0, 15));
      code   = 8'($urandom);
      link   = 8'($urandom);
      nbytes = 24'($urandom);
      cnt    = 4'($urandom);
      if (pick < 30) begin
         // Mostly short runs so the card keeps some room.
         if ($urandom_range(0, 9) < 7) cnt = 4'($urandom_range(1, 4));
         else if ($urandom_range(0, 1) == 0) cnt = 4'($urandom_range(5, 15));
         send_command(cbda_pkg::KIND_ALLOC, slot, code, link, nbytes, cnt);
      end else if (pick < 65) begin
         if ($urandom_range(0, 9) < 8) slot = chain_head_slot();
         send_command(pick < 48 ? cbda_pkg::KIND_TOGGLE : cbda_pkg::KIND_FORMAT,
                      slot, code, link, nbytes, cnt);
      end else begin
         // Well-formed entries most of the time, raw bytes otherwise.
         if ($urandom_range(0, 4) != 0) begin
            slot = 4'($urandom_range(0, cbda_pkg::SLOTS - 1));
            case ($urandom_range(0, 6))
               0: code = cbda_pkg::TYPE_FREE;
               1: code = cbda_pkg::TYPE_INITIAL;
               2: code = cbda_pkg::TYPE_MIDDLE;
               3: code = cbda_pkg::TYPE_END;
               4: code = cbda_pkg::TYPE_DEL_INIT;
               5: code = cbda_pkg::TYPE_DEL_MID;
               default: code = cbda_pkg::TYPE_DEL_END;
            endcase
            case ($urandom_range(0, 6))
               0: link = cbda_pkg::LINK_NONE;
               1: link = 8'($urandom_range(cbda_pkg::SLOTS, 254));
               default: link = 8'($urandom_range(0, cbda_pkg::SLOTS - 1));
            endcase
         end
         send_command(cbda_pkg::KIND_LOAD, slot, code, link, nbytes, cnt);
      end
   endtask

   task automatic wait_until_drained();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_out_of_range_and_no_space();
      send_command(cbda_pkg::KIND_ALLOC, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_LOAD, 4'd15, 8'hFF, 8'h00, 24'hFFFFFF, 4'd15);
      send_command(cbda_pkg::KIND_TOGGLE, 4'd15, 8'h00, 8'hFF, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_FORMAT, 4'd15, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_TOGGLE, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd0);
   endtask

   task automatic test_allocate_and_toggle();
      send_command(cbda_pkg::KIND_ALLOC, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd1);
      send_command(cbda_pkg::KIND_ALLOC, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd3);
      send_command(cbda_pkg::KIND_TOGGLE, 4'd1, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_TOGGLE, 4'd1, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_FORMAT, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd0);
   endtask

   // A full-card allocation fails while a chain is live, then fills every slot.
   task automatic test_format_and_full_card();
      send_command(cbda_pkg::KIND_ALLOC, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd15);
      send_command(cbda_pkg::KIND_FORMAT, 4'd1, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_ALLOC, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd15);
      send_command(cbda_pkg::KIND_FORMAT, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd0);
   endtask

   // Chains ended by a corrupted entry, by a link past the table, and a loop.
   task automatic test_broken_chains();
      send_command(cbda_pkg::KIND_LOAD, 4'd14, 8'hFF, cbda_pkg::LINK_NONE, 24'hFFFFFF, 4'd0);
      send_command(cbda_pkg::KIND_LOAD, 4'd0, cbda_pkg::TYPE_INITIAL, 8'd14, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_TOGGLE, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_LOAD, 4'd5, cbda_pkg::TYPE_MIDDLE, 8'd200, 24'h123456, 4'd0);
      send_command(cbda_pkg::KIND_TOGGLE, 4'd5, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_LOAD, 4'd6, cbda_pkg::TYPE_INITIAL, 8'd7, 24'h00ABCD, 4'd0);
      send_command(cbda_pkg::KIND_LOAD, 4'd7, cbda_pkg::TYPE_MIDDLE, 8'd6, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_TOGGLE, 4'd6, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_FORMAT, 4'd6, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_LOAD, 4'd14, 8'h00, 8'h00, 24'h000000, 4'd0);
      send_command(cbda_pkg::KIND_FORMAT, 4'd0, 8'h00, 8'h00, 24'h000000, 4'd0);
   endtask

   task automatic test_random_traffic(input int n);
      repeat (n) send_random_command();
   endtask

   // Hold the request side idle until every outstanding result word is back.
   task automatic test_drain_pause();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_until_drained();
   endtask

   initial begin
      for (int i = 0; i < cbda_pkg::SLOTS; i++) begin
         dir_code[i] = cbda_pkg::TYPE_FREE;
         dir_link[i] = cbda_pkg::LINK_NONE;
         dir_size[i] = '0;
      end
      while (reset) @(negedge clock);

      test_out_of_range_and_no_space();
      test_allocate_and_toggle();
      test_format_and_full_card();
      test_broken_chains();

      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      test_random_traffic(30);
      test_drain_pause();
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      test_random_traffic(50);
      test_drain_pause();
      receiver_stalls = 1'b0;
      test_random_traffic(20);
      sender_gaps = 1'b0;
      receiver_stalls = 1'b1;
      test_random_traffic(25);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));

      $display("Run covered %0d loads, %0d toggles, %0d formats, %0d allocations (%0d no space).",
               commands_by_kind[cbda_pkg::KIND_LOAD], commands_by_kind[cbda_pkg::KIND_TOGGLE],
               commands_by_kind[cbda_pkg::KIND_FORMAT], commands_by_kind[cbda_pkg::KIND_ALLOC],
               no_space_count);
      $display("%0d result words checked, %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/cbda_pkg.sv
rtl/cbda_dir_store.sv
rtl/cbda_entry_unit.sv
rtl/cbda_sequencer.sv
rtl/block_chain_directory_allocator_unit.sv
tb/tb.sv
